// ===== rtl/core/acat_pkg.sv =====
// ----------------------------------------------------------------------------
// acat_pkg
// Shared types and constants for the ARP cache aging table core.
// ----------------------------------------------------------------------------
package acat_pkg;

  // Fixed field widths of the request, result and configuration beats.
  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned AGE_W  = 8;
  localparam int unsigned SLOT_W = 4;

  // Default table depth.
  localparam int unsigned ENTRIES_DEF = 16;

  // Ages saturate at this value.
  localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

  // Reset value of the age limit register.
  localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 8'd60;

  // Request type codes.
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE,
    S_WRITE,
    S_LOOK,
    S_OUT
  } acat_state_t;

  // Write strobes from the sequencer to the entry store.
  typedef struct packed {
    logic age_we;
    logic ent_we;
  } acat_wr_ctl_t;

endpackage

// ===== rtl/core/acat_store.sv =====
// ----------------------------------------------------------------------------
// acat_store
// Entry storage: IP, MAC and age memories with one shared write address and
// one registered read port.
// ----------------------------------------------------------------------------
module acat_store #(
  parameter int unsigned ENTRIES = acat_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W  = $clog2(ENTRIES)
) (
  input  logic                           clk,
  input  acat_pkg::acat_wr_ctl_t         wr_ctl,
  input  logic [IDX_W-1:0]               waddr,
  input  logic [acat_pkg::AGE_W-1:0]     age_wdata,
  input  logic [acat_pkg::IP_W-1:0]      ip_wdata,
  input  logic [acat_pkg::MAC_W-1:0]     mac_wdata,
  input  logic [IDX_W-1:0]               raddr,
  output logic [acat_pkg::AGE_W-1:0]     age_rdata,
  output logic [acat_pkg::IP_W-1:0]      ip_rdata,
  output logic [acat_pkg::MAC_W-1:0]     mac_rdata
);

  logic [acat_pkg::AGE_W-1:0] age_mem [ENTRIES];
  logic [acat_pkg::IP_W-1:0]  ip_mem  [ENTRIES];
  logic [acat_pkg::MAC_W-1:0] mac_mem [ENTRIES];

  logic [acat_pkg::AGE_W-1:0] age_rdata_r;
  logic [acat_pkg::IP_W-1:0]  ip_rdata_r;
  logic [acat_pkg::MAC_W-1:0] mac_rdata_r;

  // A read of the address written in the same cycle returns the old data.
  // During the scan the two addresses always differ; elsewhere the sequencer
  // ignores the read data.
  always_ff @(posedge clk) begin
    if (wr_ctl.age_we) begin
      age_mem[waddr] <= age_wdata;
    end
    if (wr_ctl.ent_we) begin
      ip_mem[waddr]  <= ip_wdata;
      mac_mem[waddr] <= mac_wdata;
    end
    age_rdata_r <= age_mem[raddr];
    ip_rdata_r  <= ip_mem[raddr];
    mac_rdata_r <= mac_mem[raddr];
  end

  assign age_rdata = age_rdata_r;
  assign ip_rdata  = ip_rdata_r;
  assign mac_rdata = mac_rdata_r;

endmodule

// ===== rtl/core/arp_cache_aging_table_core.sv =====
// ----------------------------------------------------------------------------
// arp_cache_aging_table_core
// IP-to-MAC address cache with per-update aging and replacement of an invalid or else the oldest entry.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Contents
//  -------   ---------  ---------------------  ------------------------------
//  in_*      sink       in_valid / in_stall    req_type, ip_addr, mac_addr
//  out_*     source     out_valid / out_stall  hit, mac_out, slot
//  cfg_*     sink       cfg_valid / cfg_ready  age_limit (write only)
//
// An update beat scans the entry memories, one entry per cycle behind a
// registered read, and then writes the chosen slot before its result is
// presented; a lookup beat scans the same way and then presents its result.
// After the result beat is taken the core idles before it accepts again.
// The block takes one beat at a time: in_stall is high from acceptance until
// the result beat has been taken. Reset is synchronous and active low; it
// marks every entry invalid and loads the age limit with 60. The memories
// themselves are not cleared, since an invalid entry is never read out.
// While out_stall is high the result beat holds and no new request enters.
// cfg_ready is always high; the age limit is meant to change only while the
// block is idle.
// ----------------------------------------------------------------------------
module arp_cache_aging_table_core #(
  parameter int unsigned ENTRIES = acat_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Request channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [acat_pkg::IP_W-1:0]   in_ip_addr,
  input  logic [acat_pkg::MAC_W-1:0]  in_mac_addr,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic [acat_pkg::MAC_W-1:0]  out_mac_out,
  output logic [acat_pkg::SLOT_W-1:0] out_slot,
  // Configuration channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [acat_pkg::AGE_W-1:0]  cfg_data
);

  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned SLOT_EXT_W = (IDX_W > acat_pkg::SLOT_W) ? IDX_W : acat_pkg::SLOT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES);

  // Sequencer.
  acat_pkg::acat_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  scan_last;
  logic                  in_accept;

  // Control state.
  logic [ENTRIES-1:0]          valid_r;
  logic [acat_pkg::AGE_W-1:0]  age_limit_r;
  logic                        found_r, found_nxt;
  logic                        hit_r, hit_nxt;

  // Request and scan payload.
  logic [acat_pkg::IP_W-1:0]   ip_r;
  logic [acat_pkg::MAC_W-1:0]  mac_r;
  logic [IDX_W-1:0]            first_r, first_nxt;
  logic [acat_pkg::AGE_W-1:0]  best_age_r, best_age_nxt;
  logic [IDX_W-1:0]            best_idx_r, best_idx_nxt;
  logic [acat_pkg::MAC_W-1:0]  hit_mac_r, hit_mac_nxt;
  logic [IDX_W-1:0]            hit_idx_r, hit_idx_nxt;

  // Result registers.
  logic                        out_hit_r;
  logic [acat_pkg::MAC_W-1:0]  out_mac_r;
  logic [acat_pkg::SLOT_W-1:0] out_slot_r;

  // Store interface.
  acat_pkg::acat_wr_ctl_t      wr_ctl;
  logic [IDX_W-1:0]            waddr;
  logic [IDX_W-1:0]            raddr;
  logic [acat_pkg::AGE_W-1:0]  age_wdata;
  logic [acat_pkg::AGE_W-1:0]  age_rdata;
  logic [acat_pkg::IP_W-1:0]   ip_rdata;
  logic [acat_pkg::MAC_W-1:0]  mac_rdata;

  // Shared per-entry unit.
  logic                        proc_en;
  logic [IDX_W-1:0]            proc_idx;
  logic [acat_pkg::AGE_W-1:0]  age_inc;
  logic                        eff_valid;
  logic                        ip_match;
  logic [IDX_W-1:0]            pick;
  logic [IDX_W-1:0]            slot_src;
  logic [SLOT_EXT_W-1:0]       slot_ext;

  assign in_accept = in_valid && !in_stall;
  assign scan_last = (cnt_r == CNT_LAST);

  // The counter runs one step ahead of the entry being processed, because
  // the memory read data arrives in the cycle after the address is issued.
  assign proc_en  = (cnt_r != '0);
  assign proc_idx = IDX_W'(cnt_r - 1'b1);
  assign raddr    = scan_last ? '0 : cnt_r[IDX_W-1:0];

  // Age the entry under the scan: saturating increment, then test the limit.
  assign age_inc   = (age_rdata == acat_pkg::AGE_MAX) ? age_rdata
                                                      : age_rdata + 1'b1;
  assign eff_valid = valid_r[proc_idx] && !(age_inc > age_limit_r);
  assign ip_match  = valid_r[proc_idx] && (ip_rdata == ip_r);

  // Scan bookkeeping. During aging we remember the first slot that is
  // invalid after aging and the oldest slot, lowest index first on ties.
  always_comb begin
    found_nxt    = found_r;
    first_nxt    = first_r;
    best_age_nxt = best_age_r;
    best_idx_nxt = best_idx_r;
    hit_nxt      = hit_r;
    hit_mac_nxt  = hit_mac_r;
    hit_idx_nxt  = hit_idx_r;
    if (proc_en && state_r == acat_pkg::S_AGE) begin
      if (!eff_valid && !found_r) begin
        found_nxt = 1'b1;
        first_nxt = proc_idx;
      end
      if (proc_idx == '0 || age_inc > best_age_r) begin
        best_age_nxt = age_inc;
        best_idx_nxt = proc_idx;
      end
    end
    if (proc_en && state_r == acat_pkg::S_LOOK) begin
      if (ip_match && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_mac_nxt = mac_rdata;
        hit_idx_nxt = proc_idx;
      end
    end
  end

  // An invalid slot is preferred; otherwise the oldest one is replaced.
  assign pick = found_r ? first_r : best_idx_r;

  // The slot field carries the low bits of the index.
  assign slot_src = (state_r == acat_pkg::S_WRITE) ? pick : hit_idx_nxt;
  assign slot_ext = SLOT_EXT_W'(slot_src);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      acat_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_req_type == acat_pkg::REQ_LOOKUP) ? acat_pkg::S_LOOK
                                                            : acat_pkg::S_AGE;
        end
      end
      acat_pkg::S_AGE: begin
        if (scan_last) begin
          state_nxt = acat_pkg::S_WRITE;
        end
      end
      acat_pkg::S_WRITE: begin
        state_nxt = acat_pkg::S_OUT;
      end
      acat_pkg::S_LOOK: begin
        if (scan_last) begin
          state_nxt = acat_pkg::S_OUT;
        end
      end
      acat_pkg::S_OUT: begin
        if (!out_stall) begin
          state_nxt = acat_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = acat_pkg::S_IDLE;
      end
    endcase
  end

  // Output and strobe logic.
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    wr_ctl.age_we = 1'b0;
    wr_ctl.ent_we = 1'b0;
    waddr         = proc_idx;
    age_wdata     = age_inc;
    cnt_nxt       = '0;
    case (state_r)
      acat_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      acat_pkg::S_AGE: begin
        wr_ctl.age_we = proc_en;
        cnt_nxt       = scan_last ? '0 : cnt_r + 1'b1;
      end
      acat_pkg::S_WRITE: begin
        wr_ctl.age_we = 1'b1;
        wr_ctl.ent_we = 1'b1;
        waddr         = pick;
        age_wdata     = '0;
      end
      acat_pkg::S_LOOK: begin
        cnt_nxt = scan_last ? '0 : cnt_r + 1'b1;
      end
      acat_pkg::S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acat_pkg::S_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      age_limit_r <= acat_pkg::AGE_LIMIT_RST;
      found_r     <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        age_limit_r <= cfg_data;
      end
      if (in_accept) begin
        found_r <= 1'b0;
        hit_r   <= 1'b0;
      end else begin
        found_r <= found_nxt;
        hit_r   <= hit_nxt;
      end
      if (state_r == acat_pkg::S_AGE && proc_en) begin
        valid_r[proc_idx] <= eff_valid;
      end else if (state_r == acat_pkg::S_WRITE) begin
        valid_r[pick] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ip_r       <= in_ip_addr;
      mac_r      <= in_mac_addr;
      first_r    <= '0;
      best_age_r <= '0;
      best_idx_r <= '0;
      hit_mac_r  <= '0;
      hit_idx_r  <= '0;
    end else begin
      first_r    <= first_nxt;
      best_age_r <= best_age_nxt;
      best_idx_r <= best_idx_nxt;
      hit_mac_r  <= hit_mac_nxt;
      hit_idx_r  <= hit_idx_nxt;
    end
    // An update reports the written slot; a lookup reports the first match,
    // or zeros on a miss.
    if (state_r == acat_pkg::S_WRITE) begin
      out_hit_r  <= 1'b0;
      out_mac_r  <= '0;
      out_slot_r <= slot_ext[acat_pkg::SLOT_W-1:0];
    end else if (state_r == acat_pkg::S_LOOK && scan_last) begin
      out_hit_r  <= hit_nxt;
      out_mac_r  <= hit_mac_nxt;
      out_slot_r <= slot_ext[acat_pkg::SLOT_W-1:0];
    end
  end

  assign out_hit     = out_hit_r;
  assign out_mac_out = out_mac_r;
  assign out_slot    = out_slot_r;

  acat_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk       (clk),
    .wr_ctl    (wr_ctl),
    .waddr     (waddr),
    .age_wdata (age_wdata),
    .ip_wdata  (ip_r),
    .mac_wdata (mac_r),
    .raddr     (raddr),
    .age_rdata (age_rdata),
    .ip_rdata  (ip_rdata),
    .mac_rdata (mac_rdata)
  );

endmodule
